@@ design/swrt_pkg.sv @@
// Shared codes, field layout and register constants of the retransmit window tracker.
package swrt_pkg;

    // Request codes carried on s_tuser
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Result codes carried on m_tuser
    localparam logic [2:0] RESP_SENT      = 3'd0;
    localparam logic [2:0] RESP_REFUSED   = 3'd1;
    localparam logic [2:0] RESP_ACK_DONE  = 3'd2;
    localparam logic [2:0] RESP_RESEND    = 3'd3;
    localparam logic [2:0] RESP_TICK_DONE = 3'd4;

    // Field widths and output beat layout
    localparam int REQ_W       = 2;
    localparam int KIND_W      = 3;
    localparam int SEQ_FIELD_W = 16;
    localparam int OCC_W       = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_LAST_BIT = 16;
    localparam int OCC_LSB     = 17;

    // Configuration registers
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int MAXOUT_W   = 4;
    localparam int TMO_W      = 8;
    localparam logic [MAXOUT_W-1:0] MAXOUT_RESET = 4'd5;
    localparam logic [TMO_W-1:0]    TMO_RESET    = 8'd5;
    localparam logic REG_MAX_OUT = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

endpackage

@@ design/sliding_window_retransmit_tracker_top.sv @@
// Sender-side selective-repeat window tracker with a sequenced scan over a ring memory.
//
//  channel | dir | beat / access                | fields
//  --------+-----+------------------------------+----------------------------------------
//  apb     | in  | setup + access, pready high  | 0x0 max_outstanding, 0x4 timeout_ticks
//  s_*     | in  | tvalid & tready              | tuser req_type, tdata ack_seq, tlast last
//  m_*     | out | tvalid & tready              | tuser kind, tdata seq/last/occ, tlast run end
//
// A send goes straight to the result; an ack reads and compares each held frame, then releases
// acked frames from the front, and a tick reads and checks each held frame; with none held both
// go straight to the result, and the result and any resend beat wait while the output stalls.
// Each visited entry is read through the single ring memory read port and its registered read data.
// s_tready is high only while the sequencer is idle; one result waits in the output register
// while the next item is taken. Reset clears the acked bits, head and count and sets the next sequence to 1.
module sliding_window_retransmit_tracker_top #(
    parameter int WINDOW_DEPTH = 8,
    parameter int SEQ_BITS     = 16,
    parameter int TIMER_BITS   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swrt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swrt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swrt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [swrt_pkg::IN_TDATA_W-1:0]     s_tdata,  // [15:0] ack_seq
    input  logic [swrt_pkg::REQ_W-1:0]          s_tuser,  // [1:0] req_type
    input  logic                                s_tlast,  // frame_is_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swrt_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [15:0] seq, [16] resend_is_last,
                                                          // [20:17] occupancy, [23:21] zero
    output logic [swrt_pkg::KIND_W-1:0]         m_tuser,  // [2:0] resp_kind
    output logic                                m_tlast   // last_of_run
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK_RD,
        ST_ACK_CMP,
        ST_ACK_POP,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [swrt_pkg::MAXOUT_W-1:0] max_reg, max_next;
    logic [swrt_pkg::TMO_W-1:0]    tmo_reg, tmo_next;

    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [SEQ_BITS-1:0]     nseq_reg, nseq_next;
    logic [SEQ_BITS-1:0]     ackv_reg, ackv_next;
    logic [WINDOW_DEPTH-1:0] acked_reg, acked_next;

    logic [swrt_pkg::KIND_W-1:0]      res_kind_reg, res_kind_next;
    logic [swrt_pkg::SEQ_FIELD_W-1:0] res_seq_reg, res_seq_next;
    logic                             res_last_reg, res_last_next;

    logic                             ovalid_reg, ovalid_next;
    logic [swrt_pkg::KIND_W-1:0]      okind_reg, okind_next;
    logic [swrt_pkg::SEQ_FIELD_W-1:0] oseq_reg, oseq_next;
    logic                             olast_reg, olast_next;
    logic [swrt_pkg::OCC_W-1:0]       oocc_reg, oocc_next;
    logic                             orun_reg, orun_next;

    // Ring memory and its registered read port
    logic [SEQ_BITS-1:0]   seq_mem [WINDOW_DEPTH];
    logic [TIMER_BITS-1:0] timer_mem [WINDOW_DEPTH];
    logic                  last_mem [WINDOW_DEPTH];
    logic [SEQ_BITS-1:0]   rd_seq_reg;
    logic [TIMER_BITS-1:0] rd_timer_reg;
    logic                  rd_last_reg;

    logic                  ent_we, tmr_we, rd_en;
    logic [TIMER_BITS-1:0] tmr_wdata;
    logic                  ent_wlast;

    // Shared ring slot adder: head plus offset, wrapped once
    logic [CNT_W-1:0] ring_off;
    logic [IDX_W:0]   ring_sum;
    logic [IDX_W-1:0] ring_slot;
    logic [IDX_W-1:0] head_inc;

    logic                  s_beat, out_free, cfg_wr, send_ok, idx_end;
    logic [TIMER_BITS-1:0] tmr_load;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign tmr_load = TIMER_BITS'(tmo_reg);

    assign ring_off  = (state_reg == ST_IDLE) ? held_reg : idx_reg;
    assign ring_sum  = {1'b0, head_reg} + (IDX_W + 1)'(ring_off);
    assign ring_slot = (ring_sum >= DEPTH_W) ? IDX_W'(ring_sum - DEPTH_W) : IDX_W'(ring_sum);
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);

    assign send_ok = (32'(held_reg) < 32'(max_reg)) && (32'(held_reg) < WINDOW_DEPTH);
    assign idx_end = ((idx_reg + CNT_W'(1)) == held_reg);

    always_comb
    begin
        case (paddr[swrt_pkg::APB_ADDR_W-1])
            swrt_pkg::REG_TIMEOUT: prdata = swrt_pkg::APB_DATA_W'(tmo_reg);
            default:               prdata = swrt_pkg::APB_DATA_W'(max_reg);
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        max_next      = max_reg;
        tmo_next      = tmo_reg;
        head_next     = head_reg;
        held_next     = held_reg;
        idx_next      = idx_reg;
        nseq_next     = nseq_reg;
        ackv_next     = ackv_reg;
        acked_next    = acked_reg;
        res_kind_next = res_kind_reg;
        res_seq_next  = res_seq_reg;
        res_last_next = res_last_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        okind_next    = okind_reg;
        oseq_next     = oseq_reg;
        olast_next    = olast_reg;
        oocc_next     = oocc_reg;
        orun_next     = orun_reg;
        ent_we        = 1'b0;
        ent_wlast     = s_tlast;
        tmr_we        = 1'b0;
        tmr_wdata     = tmr_load;
        rd_en         = 1'b0;

        if (cfg_wr)
        begin
            case (paddr[swrt_pkg::APB_ADDR_W-1])
                swrt_pkg::REG_TIMEOUT: tmo_next = pwdata[swrt_pkg::TMO_W-1:0];
                default:               max_next = pwdata[swrt_pkg::MAXOUT_W-1:0];
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_beat)
                begin
                    idx_next = '0;
                    case (s_tuser)
                        swrt_pkg::REQ_SEND:
                        begin
                            res_seq_next = swrt_pkg::SEQ_FIELD_W'(nseq_reg);
                            state_next   = ST_EMIT;
                            if (send_ok)
                            begin
                                ent_we                = 1'b1;
                                acked_next[ring_slot] = 1'b0;
                                held_next             = held_reg + CNT_W'(1);
                                nseq_next             = nseq_reg + SEQ_BITS'(1);
                                res_kind_next         = swrt_pkg::RESP_SENT;
                                res_last_next         = s_tlast;
                            end
                            else
                            begin
                                res_kind_next = swrt_pkg::RESP_REFUSED;
                                res_last_next = 1'b0;
                            end
                        end
                        swrt_pkg::REQ_ACK:
                        begin
                            ackv_next     = SEQ_BITS'(s_tdata);
                            res_kind_next = swrt_pkg::RESP_ACK_DONE;
                            res_seq_next  = s_tdata;
                            res_last_next = 1'b0;
                            state_next    = (held_reg == '0) ? ST_EMIT : ST_ACK_RD;
                        end
                        swrt_pkg::REQ_TICK:
                        begin
                            res_kind_next = swrt_pkg::RESP_TICK_DONE;
                            res_seq_next  = '0;
                            res_last_next = 1'b0;
                            state_next    = (held_reg == '0) ? ST_EMIT : ST_TICK_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_ACK_CMP;
            end
            ST_ACK_CMP:
            begin
                if (rd_seq_reg == ackv_reg)
                begin
                    acked_next[ring_slot] = 1'b1;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = idx_end ? ST_ACK_POP : ST_ACK_RD;
            end
            ST_ACK_POP:
            begin
                // release acked frames from the front, one per cycle
                if ((held_reg != '0) && acked_reg[head_reg])
                begin
                    acked_next[head_reg] = 1'b0;
                    head_next            = head_inc;
                    held_next            = held_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_TICK_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_TICK_CHK;
            end
            ST_TICK_CHK:
            begin
                if (rd_timer_reg <= TIMER_BITS'(1))
                begin
                    // hold until the output register can take the resend beat
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        okind_next  = swrt_pkg::RESP_RESEND;
                        oseq_next   = swrt_pkg::SEQ_FIELD_W'(rd_seq_reg);
                        olast_next  = rd_last_reg;
                        oocc_next   = swrt_pkg::OCC_W'(held_reg);
                        orun_next   = 1'b0;
                        tmr_we      = 1'b1;
                        tmr_wdata   = tmr_load;
                        idx_next    = idx_reg + CNT_W'(1);
                        state_next  = idx_end ? ST_EMIT : ST_TICK_RD;
                    end
                end
                else
                begin
                    tmr_we     = 1'b1;
                    tmr_wdata  = rd_timer_reg - TIMER_BITS'(1);
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = idx_end ? ST_EMIT : ST_TICK_RD;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = res_kind_reg;
                    oseq_next   = res_seq_reg;
                    olast_next  = res_last_reg;
                    oocc_next   = swrt_pkg::OCC_W'(held_reg);
                    orun_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            max_reg      <= swrt_pkg::MAXOUT_RESET;
            tmo_reg      <= swrt_pkg::TMO_RESET;
            head_reg     <= '0;
            held_reg     <= '0;
            idx_reg      <= '0;
            nseq_reg     <= SEQ_BITS'(1);
            ackv_reg     <= '0;
            acked_reg    <= '0;
            res_kind_reg <= swrt_pkg::RESP_SENT;
            res_seq_reg  <= '0;
            res_last_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
            okind_reg    <= swrt_pkg::RESP_SENT;
            oseq_reg     <= '0;
            olast_reg    <= 1'b0;
            oocc_reg     <= '0;
            orun_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            max_reg      <= max_next;
            tmo_reg      <= tmo_next;
            head_reg     <= head_next;
            held_reg     <= held_next;
            idx_reg      <= idx_next;
            nseq_reg     <= nseq_next;
            ackv_reg     <= ackv_next;
            acked_reg    <= acked_next;
            res_kind_reg <= res_kind_next;
            res_seq_reg  <= res_seq_next;
            res_last_reg <= res_last_next;
            ovalid_reg   <= ovalid_next;
            okind_reg    <= okind_next;
            oseq_reg     <= oseq_next;
            olast_reg    <= olast_next;
            oocc_reg     <= oocc_next;
            orun_reg     <= orun_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            seq_mem[ring_slot]   <= nseq_reg;
            last_mem[ring_slot]  <= ent_wlast;
        end
        if (ent_we || tmr_we)
        begin
            timer_mem[ring_slot] <= tmr_wdata;
        end
        if (rd_en)
        begin
            rd_seq_reg   <= seq_mem[ring_slot];
            rd_timer_reg <= timer_mem[ring_slot];
            rd_last_reg  <= last_mem[ring_slot];
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = orun_reg;
    assign m_tdata  = {3'b000, oocc_reg, olast_reg, oseq_reg};

endmodule

@@ design/swrt_checker.sv @@
// Port-level checker for the retransmit window tracker, bound to the top level.
module swrt_checker #(
    parameter int WINDOW_DEPTH = 8
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [swrt_pkg::REQ_W-1:0]       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [swrt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [swrt_pkg::KIND_W-1:0]      m_tuser,
    input logic                             m_tlast
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // resend beats never close a run
    a_resend_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == swrt_pkg::RESP_RESEND) |-> !m_tlast)
        else $error("resend beat marked as end of run");

    // every other kind is the single closing beat of its run
    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == swrt_pkg::RESP_SENT) || (m_tuser == swrt_pkg::RESP_REFUSED)
            || (m_tuser == swrt_pkg::RESP_ACK_DONE) || (m_tuser == swrt_pkg::RESP_TICK_DONE))
        |-> m_tlast)
        else $error("closing result without end of run");

    // a request that yields results busies the sequencer
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != swrt_pkg::REQ_NONE) |=> !s_tready)
        else $error("input taken again before the run was produced");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[swrt_pkg::OCC_LSB +: swrt_pkg::OCC_W]) <= WINDOW_DEPTH))
        else $error("occupancy above window depth");

endmodule

bind sliding_window_retransmit_tracker_top swrt_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
) u_swrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the retransmit window tracker: random stream traffic, APB setup, scoreboard.
module testbench;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] seq;
        logic        last;
        logic [3:0]  occ;
        logic        run_end;
    } window_result_t;

    // Shadow copy of the window; builds the result beats each request should produce.
    class window_scoreboard;
        window_result_t pending_q[$];
        logic [3:0]  max_held;
        logic [7:0]  timer_load;
        logic [15:0] slot_seq[8];
        logic [7:0]  slot_timer[8];
        logic        slot_acked[8];
        logic        slot_last[8];
        logic [2:0]  head;
        logic [3:0]  held;
        logic [15:0] next_seq;
        int errors;
        int beats;
        int resends;
        int requests;

        function new();
            max_held = swrt_pkg::MAXOUT_RESET;
            timer_load = swrt_pkg::TMO_RESET;
            head = '0;
            held = '0;
            next_seq = 16'd1;
            for (int i = 0; i < 8; i++) begin
                slot_seq[i] = '0;
                slot_timer[i] = '0;
                slot_acked[i] = 1'b0;
                slot_last[i] = 1'b0;
            end
            errors = 0;
            beats = 0;
            resends = 0;
            requests = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("testbench: mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void write_reg(logic reg_sel, logic [31:0] value);
            if (reg_sel == swrt_pkg::REG_MAX_OUT)
                max_held = value[3:0];
            else
                timer_load = value[7:0];
        endfunction

        function void add_result(logic [2:0] kind, logic [15:0] seq, logic last,
                                 logic [3:0] occ, logic run_end);
            window_result_t r;
            r.kind = kind;
            r.seq = seq;
            r.last = last;
            r.occ = occ;
            r.run_end = run_end;
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void note_request(logic [1:0] req, logic [15:0] ack, logic frame_last);
            logic [3:0] limit;
            logic [2:0] s;
            requests++;
            case (req)
                swrt_pkg::REQ_SEND: begin
                    limit = (max_held > 4'd8) ? 4'd8 : max_held;
                    if (held < limit) begin
                        s = head + held[2:0];
                        slot_seq[s] = next_seq;
                        slot_last[s] = frame_last;
                        slot_timer[s] = timer_load;
                        slot_acked[s] = 1'b0;
                        held++;
                        add_result(swrt_pkg::RESP_SENT, next_seq, frame_last, held, 1'b1);
                        next_seq++;
                    end else begin
                        add_result(swrt_pkg::RESP_REFUSED, next_seq, 1'b0, held, 1'b1);
                    end
                end
                swrt_pkg::REQ_ACK: begin
                    for (int i = 0; i < held; i++) begin
                        s = head + i[2:0];
                        if (slot_seq[s] == ack)
                            slot_acked[s] = 1'b1;
                    end
                    // release acked frames from the front only
                    while (held != 0 && slot_acked[head]) begin
                        slot_acked[head] = 1'b0;
                        head++;
                        held--;
                    end
                    add_result(swrt_pkg::RESP_ACK_DONE, ack, 1'b0, held, 1'b1);
                end
                swrt_pkg::REQ_TICK: begin
                    for (int i = 0; i < held; i++) begin
                        s = head + i[2:0];
                        if (slot_timer[s] <= 8'd1) begin
                            add_result(swrt_pkg::RESP_RESEND, slot_seq[s], slot_last[s],
                                       held, 1'b0);
                            slot_timer[s] = timer_load;
                        end else begin
                            slot_timer[s] = slot_timer[s] - 8'd1;
                        end
                    end
                    add_result(swrt_pkg::RESP_TICK_DONE, 16'd0, 1'b0, held, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [15:0] seq, logic last,
                                   logic [3:0] occ, logic run_end);
            window_result_t w;
            beats++;
            if (kind == swrt_pkg::RESP_RESEND)
                resends++;
            if (pending_q.size() == 0) begin
                report($sformatf("beat with nothing pending, kind %0d seq %0d", kind, seq));
                return;
            end
            w = pending_q.pop_front();
            if (kind !== w.kind)
                report($sformatf("kind %0d, want %0d", kind, w.kind));
            if (seq !== w.seq)
                report($sformatf("seq %0d, want %0d (kind %0d)", seq, w.seq, w.kind));
            if (last !== w.last)
                report($sformatf("last mark %b, want %b (seq %0d)", last, w.last, w.seq));
            if (occ !== w.occ)
                report($sformatf("occupancy %0d, want %0d (kind %0d)", occ, w.occ, w.kind));
            if (run_end !== w.run_end)
                report($sformatf("run end %b, want %b (kind %0d)", run_end, w.run_end, w.kind));
        endfunction

        // Mostly pick a sequence number still held, sometimes anything at all.
        function logic [15:0] pick_ack();
            logic [2:0] s;
            if (held != 0 && $urandom_range(4) != 0) begin
                s = head + 3'($urandom_range(held - 1));
                return slot_seq[s];
            end
            return 16'($urandom_range(16'hFFFF));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [swrt_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [swrt_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [swrt_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [swrt_pkg::IN_TDATA_W-1:0] s_tdata = '0;             // [15:0] ack_seq
    logic [swrt_pkg::REQ_W-1:0]      s_tuser = swrt_pkg::REQ_NONE;  // [1:0] req_type
    logic        s_tlast = 1'b0;           // frame_is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [swrt_pkg::OUT_TDATA_W-1:0] m_tdata; // [15:0] seq, [16] resend_is_last, [20:17] occupancy
    logic [swrt_pkg::KIND_W-1:0]      m_tuser; // [2:0] resp_kind
    logic        m_tlast;                  // last_of_run

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic long_hold = 1'b0;

    window_scoreboard sb = new();

    sliding_window_retransmit_tracker_top uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Receiver: random back-pressure, or one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[15:0], m_tdata[swrt_pkg::OUT_LAST_BIT],
                            m_tdata[swrt_pkg::OCC_LSB +: swrt_pkg::OCC_W], m_tlast);
    end

    task automatic push_request(input logic [1:0] req, input logic [15:0] ack,
                                input logic frame_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= ack;
        s_tlast <= frame_last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(req, ack, frame_last);
    endtask

    task automatic random_request();
        int pick;
        logic [15:0] noise;
        pick = $urandom_range(99);
        noise = 16'($urandom_range(16'hFFFF));
        if (pick < 40)
            push_request(swrt_pkg::REQ_SEND, noise, 1'($urandom_range(1)));
        else if (pick < 70)
            push_request(swrt_pkg::REQ_ACK, sb.pick_ack(), 1'($urandom_range(1)));
        else if (pick < 95)
            push_request(swrt_pkg::REQ_TICK, noise, 1'($urandom_range(1)));
        else
            push_request(swrt_pkg::REQ_NONE, noise, 1'($urandom_range(1)));
    endtask

    // Drop valid and hold until every pending beat is out and the scan has finished.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(reg_sel, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_settings(input int max_frames, input int timeout);
        drain();
        apb_write(swrt_pkg::REG_MAX_OUT, 32'(max_frames));
        apb_write(swrt_pkg::REG_TIMEOUT, 32'(timeout));
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 24; recv_idle_pct = 86; end
            1: begin send_idle_pct = 86; recv_idle_pct = 24; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    int limits[7]   = '{0, 15, 1, 8, 3, 7, 8};
    int timeouts[7] = '{3, 0, 1, 255, 2, 4, 1};

    initial
    begin
        set_idling(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, limit 5, timeout 5.
        push_request(swrt_pkg::REQ_NONE, 16'hFFFF, 1'b1);
        push_request(swrt_pkg::REQ_ACK, 16'h0000, 1'b1);
        push_request(swrt_pkg::REQ_ACK, 16'hFFFF, 1'b0);
        push_request(swrt_pkg::REQ_TICK, 16'h0000, 1'b0);
        for (int i = 0; i < 6; i++)
            push_request(swrt_pkg::REQ_SEND, 16'hFFFF, i[0]);
        // fifth tick runs the timers out
        for (int i = 0; i < 5; i++)
            push_request(swrt_pkg::REQ_TICK, 16'hFFFF, 1'b1);
        push_request(swrt_pkg::REQ_ACK, 16'd3, 1'b0);
        push_request(swrt_pkg::REQ_ACK, 16'd1, 1'b0);
        push_request(swrt_pkg::REQ_ACK, 16'd2, 1'b1);
        push_request(swrt_pkg::REQ_ACK, 16'h1234, 1'b0);
        push_request(swrt_pkg::REQ_TICK, 16'h0000, 1'b0);

        for (int p = 0; p < 7; p++)
        begin
            apply_settings(limits[p], timeouts[p]);
            set_idling(p < 3 ? 0 : (p < 5 ? 1 : 2));
            for (int n = 0; n < 13; n++)
            begin
                if (p == 1 && n == 8)
                    drain();
                if (p == 3 && n == 4)
                    long_hold = 1'b1;
                random_request();
            end
        end
        drain();

        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d beats never arrived", sb.pending_q.size()));
        $display("testbench: %0d requests, %0d result beats checked, %0d resends",
                 sb.requests, sb.beats, sb.resends);
        $display("testbench: limits 0..15, timeouts 0..255, long output hold-off included");
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ sliding_window_retransmit_tracker_top.f @@
design/swrt_pkg.sv
design/sliding_window_retransmit_tracker_top.sv
design/swrt_checker.sv
test/testbench.sv
